[design/cdfir_pkg.sv]
`timescale 1ns / 1ps
// Shared types, constants and elaboration-time coefficient functions for the
// complex decimating FIR. No dependencies.
package cdfir_pkg;

	// Default build parameters
	localparam int DEF_TAPS      = 1025;
	localparam int DEF_DECIM     = 48;
	localparam int DEF_COEF_BITS = 18;

	// Sample format
	localparam int SAMPLE_W = 16;
	localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 16'sh7FFF;
	localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 16'sh8000;

	// Filter design constants (Q30 where noted)
	localparam longint unsigned FS_HZ       = 64'd192000;
	localparam longint unsigned FC_HZ       = 64'd1900;
	localparam longint unsigned TWO_FS_HZ   = 64'd2 * FS_HZ;
	localparam longint unsigned SINC_PEAK_Q30 = ((64'd2 * FC_HZ) << 30) / FS_HZ;
	localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
	localparam longint          PI_Q30      = 64'sd3373259426;
	localparam longint          WIN_A_Q30   = 64'sd579820585;
	localparam longint          WIN_B_Q30   = 64'sd493921239;

	// Controller states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MAC,
		ST_DRAIN
	} cdfir_state_t;

	// Commands from the controller to the datapath
	typedef struct packed {
		logic wr_en;
		logic rd_en;
		logic rd_live;
		logic acc_clear;
		logic out_load;
	} cdfir_cmd_t;

	// Status from the datapath to the controller
	typedef struct packed {
		logic busy;
	} cdfir_status_t;

	// Unsigned quotient by shift and subtract, one bit per step
	function automatic longint unsigned cdfir_udiv(input longint unsigned num,
			input longint unsigned den);
		longint unsigned quo;
		longint unsigned rem;
		int              b;
		quo = 64'd0;
		rem = 64'd0;
		for (b = 63; b >= 0; b--) begin
			rem = (rem << 1) | ((num >> b) & 64'd1);
			if (rem >= den) begin
				rem = rem - den;
				quo = quo | (64'd1 << b);
			end
		end
		return quo;
	endfunction

	// Signed quotient, truncated toward zero
	function automatic longint cdfir_sdiv(input longint num, input longint den);
		longint unsigned qm;
		qm = cdfir_udiv($unsigned((num < 0) ? -num : num), $unsigned((den < 0) ? -den : den));
		return ((num < 0) != (den < 0)) ? -longint'(qm) : longint'(qm);
	endfunction

	// Sine of a 32-bit fraction of a turn, Q30, quarter-wave reduced Taylor series
	function automatic longint cdfir_sin_turn(input longint unsigned p);
		longint unsigned quad;
		longint unsigned r;
		longint unsigned a;
		longint unsigned a2;
		longint unsigned t;
		longint unsigned dv;
		longint          s;
		int              k;
		quad = p >> 30;
		r    = p & 64'h3FFF_FFFF;
		if (quad[0])
			r = 64'h4000_0000 - r;
		a  = (r * HALF_PI_Q30) >> 30;
		a2 = (a * a) >> 30;
		t  = a;
		s  = longint'(a);
		for (k = 1; k <= 6; k++) begin
			dv = longint'((2 * k) * (2 * k + 1));
			t  = cdfir_udiv((t * a2) >> 30, dv);
			if (k[0])
				s = s - longint'(t);
			else
				s = s + longint'(t);
		end
		return quad[1] ? -s : s;
	endfunction

	// Q30 product, rounded half away from zero
	function automatic longint cdfir_mul_q30(input longint a, input longint b);
		logic            neg;
		longint unsigned ua;
		longint unsigned ub;
		longint unsigned m;
		neg = (a < 0) != (b < 0);
		ua  = (a < 0) ? -a : a;
		ub  = (b < 0) ? -b : b;
		m   = (ua * ub + 64'd536870912) >> 30;
		return neg ? -longint'(m) : longint'(m);
	endfunction

	// Unnormalised windowed sinc tap, Q30
	function automatic longint cdfir_h(input int n, input int taps);
		longint          m;
		longint          x2;
		longint          s;
		longint          w;
		longint unsigned den;
		longint unsigned ax;
		longint unsigned num;
		longint unsigned p;
		longint unsigned nn;
		longint unsigned wp;
		m  = longint'(taps) - 64'sd1;
		nn = longint'(n);
		if (m > 0)
			den = m;
		else
			den = 64'd1;
		x2 = 64'sd2 * longint'(n) - m;
		ax = (x2 < 0) ? -x2 : x2;
		if (ax == 64'd0) begin
			s = longint'(SINC_PEAK_Q30);
		end else begin
			// Reduce the phase to one turn
			num = FC_HZ * ax;
			num = num - cdfir_udiv(num, TWO_FS_HZ) * TWO_FS_HZ;
			p   = cdfir_udiv(num << 32, TWO_FS_HZ) & 64'hFFFF_FFFF;
			s   = cdfir_sdiv(cdfir_sin_turn(p) * 64'sd2147483648, PI_Q30 * longint'(ax));
		end
		wp = (cdfir_udiv(nn << 32, den) + 64'h4000_0000) & 64'hFFFF_FFFF;
		w  = WIN_A_Q30 - cdfir_mul_q30(WIN_B_Q30, cdfir_sin_turn(wp));
		return cdfir_mul_q30(s, w);
	endfunction

	// Sum of all unnormalised taps, never below one
	function automatic longint cdfir_h_sum(input int taps);
		longint sum;
		int     n;
		sum = 64'sd0;
		for (n = 0; n < taps; n++)
			sum = sum + cdfir_h(n, taps);
		if (sum <= 0)
			sum = 64'sd1;
		return sum;
	endfunction

	// Normalised and saturated coefficient at Q1.(coef_bits-1)
	function automatic longint cdfir_coef(input int n, input int taps, input int coef_bits,
			input longint sum);
		longint          v;
		longint          sc;
		longint          lim;
		longint unsigned mag;
		longint unsigned su;
		longint unsigned c;
		v   = cdfir_h(n, taps);
		mag = (v < 0) ? -v : v;
		su  = sum;
		c   = cdfir_udiv((mag << (coef_bits - 1)) + (su >> 1), su);
		sc  = (v < 0) ? -longint'(c) : longint'(c);
		lim = 64'sd1 <<< (coef_bits - 1);
		if (sc > lim - 1)
			sc = lim - 1;
		if (sc < -lim)
			sc = -lim;
		return sc;
	endfunction

endpackage

[design/complex_decimating_fir.sv]
`timescale 1ns / 1ps
// Complex decimating low-pass FIR: top level joining controller and datapath.
// Depends on cdfir_pkg, cdfir_ctrl and cdfir_dp.
//
// Takes one complex Q1.15 sample per request and returns one filtered Q1.15
// sample for every DECIM-th input, using a TAPS-tap Hamming-windowed sinc
// (1900 Hz cutoff at 192 kHz, unity DC gain, Q1.(COEF_BITS-1) coefficients
// built at elaboration). Non-triggering samples are taken without stalling.
// The triggering sample starts a single shared complex MAC that walks the
// history memory and coefficient ROM one tap per cycle, then drains the
// pipeline and loads the output; sample_stall is high throughout, so no new
// sample is taken until the result is loaded. The result sits in an
// output register, so new samples are taken while it waits; the next result
// waits only if the old one is still held when the next MAC finishes. The
// history reads as zero until written, tracked by a fill count: no clearing
// pass after reset.
module complex_decimating_fir import cdfir_pkg::*; #(
	parameter int TAPS      = DEF_TAPS,
	parameter int DECIM     = DEF_DECIM,
	parameter int COEF_BITS = DEF_COEF_BITS
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       sample_valid,
	output logic                       sample_stall,
	input  logic signed [SAMPLE_W-1:0] sample_i,
	input  logic signed [SAMPLE_W-1:0] sample_q,
	output logic                       filtered_valid,
	input  logic                       filtered_stall,
	output logic signed [SAMPLE_W-1:0] filtered_i,
	output logic signed [SAMPLE_W-1:0] filtered_q
);

	localparam int PTR_W = $clog2(TAPS);

	cdfir_cmd_t       cmd;
	cdfir_status_t    status;
	logic [PTR_W-1:0] wr_addr;
	logic [PTR_W-1:0] rd_addr;
	logic [PTR_W-1:0] rom_addr;

	// Sequencing and handshakes
	cdfir_ctrl #(
		.TAPS  (TAPS),
		.DECIM (DECIM)
	) u_ctrl (
		.clk            (clk),
		.arst_n         (arst_n),
		.sample_valid   (sample_valid),
		.sample_stall   (sample_stall),
		.filtered_valid (filtered_valid),
		.filtered_stall (filtered_stall),
		.status         (status),
		.cmd            (cmd),
		.wr_addr        (wr_addr),
		.rd_addr        (rd_addr),
		.rom_addr       (rom_addr)
	);

	// Storage and arithmetic
	cdfir_dp #(
		.TAPS      (TAPS),
		.COEF_BITS (COEF_BITS)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.wr_addr    (wr_addr),
		.rd_addr    (rd_addr),
		.rom_addr   (rom_addr),
		.sample_i   (sample_i),
		.sample_q   (sample_q),
		.status     (status),
		.filtered_i (filtered_i),
		.filtered_q (filtered_q)
	);

endmodule

[design/cdfir_ctrl.sv]
`timescale 1ns / 1ps
// Controller for the complex decimating FIR: handshakes, history pointers,
// decimation count and the tap sequencer. Depends on cdfir_pkg.
module cdfir_ctrl import cdfir_pkg::*; #(
	parameter int TAPS  = DEF_TAPS,
	parameter int DECIM = DEF_DECIM
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       sample_valid,
	output logic                       sample_stall,
	output logic                       filtered_valid,
	input  logic                       filtered_stall,
	input  cdfir_status_t              status,
	output cdfir_cmd_t                 cmd,
	output logic [$clog2(TAPS)-1:0]    wr_addr,
	output logic [$clog2(TAPS)-1:0]    rd_addr,
	output logic [$clog2(TAPS)-1:0]    rom_addr
);

	localparam int PTR_W  = $clog2(TAPS);
	localparam int FILL_W = $clog2(TAPS + 1);
	localparam int DEC_W  = (DECIM > 1) ? $clog2(DECIM) : 1;
	localparam logic [PTR_W-1:0]  PTR_LAST  = PTR_W'(TAPS - 1);
	localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(TAPS);
	localparam logic [DEC_W-1:0]  DEC_LAST  = DEC_W'(DECIM - 1);

	cdfir_state_t      state_q;
	cdfir_state_t      state_nxt;
	logic [PTR_W-1:0]  wptr_q;
	logic [PTR_W-1:0]  wptr_nxt;
	logic [PTR_W-1:0]  rd_slot_q;
	logic [PTR_W-1:0]  tap_q;
	logic [FILL_W-1:0] fill_q;
	logic [DEC_W-1:0]  decim_q;
	logic              out_valid_q;
	logic              accept;
	logic              last_in;
	logic              out_free;

	// Request and output slot status
	assign accept   = sample_valid && (state_q == ST_IDLE);
	assign last_in  = (decim_q == DEC_LAST);
	assign out_free = !out_valid_q || !filtered_stall;
	assign wptr_nxt = (wptr_q == PTR_LAST) ? '0 : wptr_q + 1'b1;

	// Next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept && last_in)
					state_nxt = ST_MAC;
			end
			ST_MAC: begin
				if (tap_q == PTR_LAST)
					state_nxt = ST_DRAIN;
			end
			ST_DRAIN: begin
				if (!status.busy && out_free)
					state_nxt = ST_IDLE;
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	// Commands and handshake outputs
	always_comb begin
		cmd            = '0;
		sample_stall   = 1'b1;
		filtered_valid = out_valid_q;
		wr_addr        = wptr_q;
		rd_addr        = rd_slot_q;
		rom_addr       = tap_q;
		unique case (state_q)
			ST_IDLE: begin
				sample_stall  = 1'b0;
				cmd.wr_en     = accept;
				cmd.acc_clear = accept && last_in;
			end
			ST_MAC: begin
				cmd.rd_en   = 1'b1;
				// Slots never written read as zero
				cmd.rd_live = (fill_q == FILL_FULL) || (FILL_W'(rd_slot_q) < fill_q);
			end
			ST_DRAIN: begin
				cmd.out_load = !status.busy && out_free;
			end
			default: ;
		endcase
	end

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// Advance history pointers, decimation count and tap sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q    <= '0;
			rd_slot_q <= '0;
			tap_q     <= '0;
			fill_q    <= '0;
			decim_q   <= '0;
		end else begin
			if (accept) begin
				wptr_q <= wptr_nxt;
				if (fill_q != FILL_FULL)
					fill_q <= fill_q + 1'b1;
				if (last_in) begin
					decim_q   <= '0;
					rd_slot_q <= wptr_nxt;
					tap_q     <= '0;
				end else begin
					decim_q <= decim_q + 1'b1;
				end
			end
			if (state_q == ST_MAC) begin
				tap_q     <= tap_q + 1'b1;
				rd_slot_q <= (rd_slot_q == PTR_LAST) ? '0 : rd_slot_q + 1'b1;
			end
		end
	end

	// Hold the result until the downstream side takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.out_load)
				out_valid_q <= 1'b1;
			else if (!filtered_stall)
				out_valid_q <= 1'b0;
		end
	end

endmodule

[design/cdfir_dp.sv]
`timescale 1ns / 1ps
// Datapath for the complex decimating FIR: sample history memory, coefficient
// ROM, complex MAC pipeline, rounding and output register. Depends on cdfir_pkg.
module cdfir_dp import cdfir_pkg::*; #(
	parameter int TAPS      = DEF_TAPS,
	parameter int COEF_BITS = DEF_COEF_BITS
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  cdfir_cmd_t                 cmd,
	input  logic [$clog2(TAPS)-1:0]    wr_addr,
	input  logic [$clog2(TAPS)-1:0]    rd_addr,
	input  logic [$clog2(TAPS)-1:0]    rom_addr,
	input  logic signed [SAMPLE_W-1:0] sample_i,
	input  logic signed [SAMPLE_W-1:0] sample_q,
	output cdfir_status_t              status,
	output logic signed [SAMPLE_W-1:0] filtered_i,
	output logic signed [SAMPLE_W-1:0] filtered_q
);

	localparam int PROD_W = SAMPLE_W + COEF_BITS;
	localparam int ACC_W  = SAMPLE_W + COEF_BITS + $clog2(TAPS) + 1;
	localparam logic signed [ACC_W-1:0] HALF_LSB = ACC_W'(1) << (COEF_BITS - 2);
	localparam logic signed [ACC_W-1:0] SAT_HI =
		{{(ACC_W-SAMPLE_W+1){1'b0}}, {(SAMPLE_W-1){1'b1}}};
	localparam logic signed [ACC_W-1:0] SAT_LO =
		{{(ACC_W-SAMPLE_W+1){1'b1}}, {(SAMPLE_W-1){1'b0}}};
	localparam longint H_SUM = cdfir_h_sum(TAPS);

	logic [2*SAMPLE_W-1:0]       hist_mem [TAPS];
	logic signed [COEF_BITS-1:0] coef_rom [TAPS];

	logic [2*SAMPLE_W-1:0]       hist_s1;
	logic signed [COEF_BITS-1:0] coef_s1;
	logic                        v_s1;
	logic                        live_s1;
	logic signed [PROD_W-1:0]    prod_i_s2;
	logic signed [PROD_W-1:0]    prod_q_s2;
	logic                        v_s2;
	logic signed [ACC_W-1:0]     acc_i_q;
	logic signed [ACC_W-1:0]     acc_q_q;
	logic signed [SAMPLE_W-1:0]  filtered_i_q;
	logic signed [SAMPLE_W-1:0]  filtered_q_q;

	// Round half up to Q1.15 and saturate
	function automatic logic signed [SAMPLE_W-1:0] round_sat(input logic signed [ACC_W-1:0] acc);
		logic signed [ACC_W-1:0] v;
		v = (acc + HALF_LSB) >>> (COEF_BITS - 1);
		if (v > SAT_HI)
			return SAMPLE_MAX;
		else if (v < SAT_LO)
			return SAMPLE_MIN;
		else
			return v[SAMPLE_W-1:0];
	endfunction

	// Coefficient ROM, built at elaboration
	for (genvar g = 0; g < TAPS; g++) begin : g_rom
		localparam longint CV = cdfir_coef(g, TAPS, COEF_BITS, H_SUM);
		assign coef_rom[g] = COEF_BITS'(CV);
	end

	// History write, Q in the upper half
	always_ff @(posedge clk) begin
		if (cmd.wr_en)
			hist_mem[wr_addr] <= {sample_q, sample_i};
	end

	// Stage 1: registered history and ROM reads
	always_ff @(posedge clk) begin
		if (cmd.rd_en) begin
			hist_s1 <= hist_mem[rd_addr];
			coef_s1 <= coef_rom[rom_addr];
		end
	end

	// Stage 2: complex products, dead slots give zero
	always_ff @(posedge clk) begin
		if (live_s1) begin
			prod_i_s2 <= PROD_W'(signed'(hist_s1[SAMPLE_W-1:0])) * PROD_W'(coef_s1);
			prod_q_s2 <= PROD_W'(signed'(hist_s1[2*SAMPLE_W-1:SAMPLE_W])) * PROD_W'(coef_s1);
		end else begin
			prod_i_s2 <= '0;
			prod_q_s2 <= '0;
		end
	end

	// Pipeline valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			live_s1 <= 1'b0;
			v_s2    <= 1'b0;
		end else begin
			v_s1    <= cmd.rd_en;
			live_s1 <= cmd.rd_en && cmd.rd_live;
			v_s2    <= v_s1;
		end
	end

	assign status.busy = v_s1 || v_s2;

	// Accumulate
	always_ff @(posedge clk) begin
		if (cmd.acc_clear) begin
			acc_i_q <= '0;
			acc_q_q <= '0;
		end else if (v_s2) begin
			acc_i_q <= acc_i_q + {{(ACC_W-PROD_W){prod_i_s2[PROD_W-1]}}, prod_i_s2};
			acc_q_q <= acc_q_q + {{(ACC_W-PROD_W){prod_q_s2[PROD_W-1]}}, prod_q_s2};
		end
	end

	// Output register
	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			filtered_i_q <= round_sat(acc_i_q);
			filtered_q_q <= round_sat(acc_q_q);
		end
	end

	assign filtered_i = filtered_i_q;
	assign filtered_q = filtered_q_q;

endmodule

[verif/cdfir_output_check.sv]
`timescale 1ns / 1ps
// Self-checking monitor for complex_decimating_fir: predicts every filtered request
// from its own tap history and coefficient table and compares it with the block's output.
// Depends on cdfir_pkg for the sample width and default build parameters.
module cdfir_output_check import cdfir_pkg::*; #(
	parameter int TAPS      = DEF_TAPS,
	parameter int DECIM     = DEF_DECIM,
	parameter int COEF_BITS = DEF_COEF_BITS
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       sample_valid,
	input  logic                       sample_stall,
	input  logic signed [SAMPLE_W-1:0] sample_i,
	input  logic signed [SAMPLE_W-1:0] sample_q,
	input  logic                       filtered_valid,
	input  logic                       filtered_stall,
	input  logic signed [SAMPLE_W-1:0] filtered_i,
	input  logic signed [SAMPLE_W-1:0] filtered_q,
	output int                         fail_count,
	output int                         outstanding
);

	// Filter design figures, Q30 where scaled
	localparam longint unsigned RATE_HZ      = 64'd192000;
	localparam longint unsigned CUTOFF_HZ    = 64'd1900;
	localparam longint unsigned QUARTER_TURN = 64'd1686629713;
	localparam longint          HALF_TURN    = 64'sd3373259426;
	localparam longint          HAMMING_A    = 64'sd579820585;
	localparam longint          HAMMING_B    = 64'sd493921239;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] i;
		logic signed [SAMPLE_W-1:0] q;
	} iq_t;

	iq_t    tap_history [TAPS];
	longint coef_table [TAPS];
	int     next_slot;
	int     since_output;
	iq_t    filtered_due [$];
	iq_t    oldest;
	longint sum_i;
	longint sum_q;
	int     slot;
	int     t;

	// Sine of a 32-bit fraction of a turn in Q30: fold to a quarter wave, Taylor to x^13
	function automatic longint sine_q30(input longint unsigned turn_frac);
		longint unsigned quadrant;
		longint unsigned frac;
		longint unsigned ang;
		longint unsigned ang_sq;
		longint unsigned term;
		longint          acc;
		int              k;
		quadrant = turn_frac >> 30;
		frac     = turn_frac & 64'h3FFF_FFFF;
		if (quadrant[0])
			frac = 64'h4000_0000 - frac;
		ang    = (frac * QUARTER_TURN) >> 30;
		ang_sq = (ang * ang) >> 30;
		term   = ang;
		acc    = $signed(ang);
		for (k = 1; k <= 6; k++) begin
			term = ((term * ang_sq) >> 30) / $unsigned(64'(2 * k * (2 * k + 1)));
			if (k[0])
				acc = acc - $signed(term);
			else
				acc = acc + $signed(term);
		end
		return quadrant[1] ? -acc : acc;
	endfunction

	// Q30 product, rounded half away from zero
	function automatic longint q30_product(input longint a, input longint b);
		longint unsigned ma;
		longint unsigned mb;
		longint unsigned m;
		ma = (a < 0) ? -a : a;
		mb = (b < 0) ? -b : b;
		m  = (ma * mb + 64'd536870912) >> 30;
		return ((a < 0) != (b < 0)) ? -$signed(m) : $signed(m);
	endfunction

	// Round half up from Q(14+COEF_BITS) to Q1.15 and clamp
	function automatic logic signed [SAMPLE_W-1:0] round_to_q15(input longint acc);
		longint r;
		r = (acc + (64'sd1 <<< (COEF_BITS - 2))) >>> (COEF_BITS - 1);
		if (r > 64'sd32767)
			r = 64'sd32767;
		if (r < -64'sd32768)
			r = -64'sd32768;
		return r[SAMPLE_W-1:0];
	endfunction

	// Build the windowed sinc table, normalise to unity DC gain, clear the history
	initial begin
		longint          centre;
		longint          x2;
		longint          sinc;
		longint          win;
		longint          total;
		longint          lim;
		longint          sc;
		longint unsigned ax;
		longint unsigned num;
		longint unsigned ph;
		longint unsigned den;
		longint unsigned mag;
		longint unsigned c;
		int              n;
		fail_count   = 0;
		outstanding  = 0;
		next_slot    = 0;
		since_output = 0;
		centre       = TAPS - 1;
		den          = (centre > 0) ? centre : 1;
		total        = 0;
		for (n = 0; n < TAPS; n++) begin
			tap_history[n] = '0;
			x2 = 64'sd2 * n - centre;
			ax = (x2 < 0) ? -x2 : x2;
			if (ax == 0) begin
				sinc = $signed(((64'd2 * CUTOFF_HZ) << 30) / RATE_HZ);
			end else begin
				num  = (CUTOFF_HZ * ax) % (64'd2 * RATE_HZ);
				ph   = ((num << 32) / (64'd2 * RATE_HZ)) & 64'hFFFF_FFFF;
				sinc = (sine_q30(ph) * 64'sd2147483648) / (HALF_TURN * $signed(ax));
			end
			ph  = ((64'(n) << 32) / den + 64'h4000_0000) & 64'hFFFF_FFFF;
			win = HAMMING_A - q30_product(HAMMING_B, sine_q30(ph));
			coef_table[n] = q30_product(sinc, win);
			total = total + coef_table[n];
		end
		if (total <= 0)
			total = 1;
		lim = 64'sd1 <<< (COEF_BITS - 1);
		for (n = 0; n < TAPS; n++) begin
			mag = (coef_table[n] < 0) ? -coef_table[n] : coef_table[n];
			c   = ((mag << (COEF_BITS - 1)) + $unsigned(total) / 2) / $unsigned(total);
			sc  = (coef_table[n] < 0) ? -$signed(c) : $signed(c);
			if (sc > lim - 1)
				sc = lim - 1;
			if (sc < -lim)
				sc = -lim;
			coef_table[n] = sc;
		end
	end

	// Compare each output request first, then fold any new sample into the history
	always @(posedge clk) begin
		if (arst_n) begin
			if (filtered_valid && !filtered_stall) begin
				if (filtered_due.size() == 0) begin
					$error("unexpected filtered request: filtered_i=%0d filtered_q=%0d",
						filtered_i, filtered_q);
					fail_count++;
				end else begin
					oldest = filtered_due.pop_front();
					if (filtered_i !== oldest.i) begin
						$error("filtered_i: expected %0d, actual %0d", oldest.i, filtered_i);
						fail_count++;
					end
					if (filtered_q !== oldest.q) begin
						$error("filtered_q: expected %0d, actual %0d", oldest.q, filtered_q);
						fail_count++;
					end
				end
			end
			if (sample_valid && !sample_stall) begin
				tap_history[next_slot] = '{i: sample_i, q: sample_q};
				next_slot = (next_slot + 1) % TAPS;
				since_output++;
				// On every DECIM-th sample, run the dot product oldest entry first
				if (since_output == DECIM) begin
					since_output = 0;
					sum_i = 0;
					sum_q = 0;
					slot  = next_slot;
					for (t = 0; t < TAPS; t++) begin
						sum_i = sum_i + coef_table[t] * longint'(tap_history[slot].i);
						sum_q = sum_q + coef_table[t] * longint'(tap_history[slot].q);
						slot  = (slot + 1) % TAPS;
					end
					filtered_due.push_back('{i: round_to_q15(sum_i), q: round_to_q15(sum_q)});
				end
			end
			outstanding = filtered_due.size();
		end
	end

endmodule

[verif/tb_complex_decimating_fir.sv]
`timescale 1ns / 1ps
// Top-level testbench for complex_decimating_fir: drives sample requests in bursts,
// stalls the output side, and reports the verdict. Depends on cdfir_pkg and cdfir_output_check.
module tb_complex_decimating_fir;
	import cdfir_pkg::*;

	localparam int TAPS         = DEF_TAPS;
	localparam int DECIM        = DEF_DECIM;
	localparam int ITEMS        = 1350;
	localparam int CYCLE_LIMIT  = 1000000;
	localparam int DRAIN_CYCLES = 2 * (TAPS + 3);

	typedef enum {
		RUN_NOISE,
		RUN_QUIET,
		RUN_DC,
		RUN_MATCHED
	} run_kind_t;

	logic                       clk            = 1'b0;
	logic                       arst_n         = 1'b0;
	logic                       sample_valid   = 1'b0;
	logic                       sample_stall;
	logic signed [SAMPLE_W-1:0] sample_i       = '0;
	logic signed [SAMPLE_W-1:0] sample_q       = '0;
	logic                       filtered_valid;
	logic                       filtered_stall = 1'b0;
	logic signed [SAMPLE_W-1:0] filtered_i;
	logic signed [SAMPLE_W-1:0] filtered_q;
	int                         fail_count;
	int                         outstanding;

	int sent        = 0;
	int burst_left  = 0;
	int cycles      = 0;
	int stall_mode  = 0;
	int stall_left  = 0;

	always #4 clk = ~clk;

	complex_decimating_fir dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.sample_valid   (sample_valid),
		.sample_stall   (sample_stall),
		.sample_i       (sample_i),
		.sample_q       (sample_q),
		.filtered_valid (filtered_valid),
		.filtered_stall (filtered_stall),
		.filtered_i     (filtered_i),
		.filtered_q     (filtered_q)
	);

	cdfir_output_check check_unit (
		.clk            (clk),
		.arst_n         (arst_n),
		.sample_valid   (sample_valid),
		.sample_stall   (sample_stall),
		.sample_i       (sample_i),
		.sample_q       (sample_q),
		.filtered_valid (filtered_valid),
		.filtered_stall (filtered_stall),
		.filtered_i     (filtered_i),
		.filtered_q     (filtered_q),
		.fail_count     (fail_count),
		.outstanding    (outstanding)
	);

	// Send one sample request, opening a new burst with an optional gap when the last one ends
	task automatic push_sample(input logic signed [SAMPLE_W-1:0] si,
			input logic signed [SAMPLE_W-1:0] sq);
		int gap;
		if (burst_left == 0) begin
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(100, 300)
				: $urandom_range(1, 24);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				@(negedge clk);
				sample_valid <= 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
		end
		@(negedge clk);
		sample_valid <= 1'b1;
		sample_i     <= si;
		sample_q     <= sq;
		do
			@(posedge clk);
		while (sample_stall);
		burst_left--;
		sent++;
	endtask

	// Stall the output side: free-running, random, or a fixed duty pattern
	always @(negedge clk) begin
		if (stall_left == 0) begin
			stall_mode = $urandom_range(0, 2);
			stall_left = $urandom_range(50, 600);
		end
		stall_left--;
		case (stall_mode)
			0: filtered_stall <= 1'b0;
			1: filtered_stall <= ($urandom_range(0, 2) == 0);
			default: filtered_stall <= ((stall_left % 16) < 10);
		endcase
	end

	// Abort a hung run
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	initial begin
		logic [31:0]                corners [12];
		run_kind_t                  kind;
		logic signed [SAMPLE_W-1:0] dc_i;
		logic signed [SAMPLE_W-1:0] dc_q;
		logic                       flip;
		logic                       pos;
		longint unsigned            lobe;
		int                         groups;
		int                         target;
		int                         k;
		int                         ax;
		int                         pick;
		int                         j;
		// Q in the upper half, I in the lower half
		corners = '{32'h0000_0000, 32'h7FFF_7FFF, 32'h8000_8000, 32'h8000_7FFF,
			32'h7FFF_8000, 32'h0001_FFFF, 32'hFFFF_0001, 32'hAAAA_5555,
			32'h5555_AAAA, 32'hFFFF_FFFF, 32'h7FFF_0000, 32'h0000_8000};

		// Hold reset, then release it away from the rising edge
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Field extremes and bit patterns
		for (j = 0; j < 12; j++)
			push_sample(corners[j][15:0], corners[j][31:16]);

		// Random runs, each ending on a decimation boundary or at the item count
		while (sent < ITEMS) begin
			pick = $urandom_range(0, 99);
			if (pick < 45) begin
				kind   = RUN_NOISE;
				groups = $urandom_range(1, 4);
			end else if (pick < 70) begin
				kind   = RUN_QUIET;
				groups = $urandom_range(1, 4);
			end else if (pick < 88) begin
				kind   = RUN_DC;
				groups = $urandom_range(2, 23);
			end else begin
				kind   = RUN_MATCHED;
				groups = 23;
			end
			target = (sent / DECIM + groups) * DECIM;
			if (target > ITEMS)
				target = ITEMS;
			case ($urandom_range(0, 3))
				0: begin
					dc_i = SAMPLE_MAX;
					dc_q = SAMPLE_MAX;
				end
				1: begin
					dc_i = SAMPLE_MIN;
					dc_q = SAMPLE_MIN;
				end
				2: begin
					dc_i = SAMPLE_MAX;
					dc_q = SAMPLE_MIN;
				end
				default: begin
					dc_i = 16'($urandom);
					dc_q = 16'($urandom);
				end
			endcase
			flip = $urandom_range(0, 1);
			while (sent < target) begin
				case (kind)
					RUN_NOISE: push_sample(16'($urandom), 16'($urandom));
					RUN_QUIET: push_sample(16'(int'($urandom_range(0, 511)) - 256),
						16'(int'($urandom_range(0, 511)) - 256));
					RUN_DC: push_sample(dc_i, dc_q);
					default: begin
						// Match each sample's sign to the tap it meets at the run's last output
						k = target - (sent + 1);
						if (k >= TAPS) begin
							push_sample(16'($urandom), 16'($urandom));
						end else begin
							ax   = TAPS - 1 - 2 * k;
							ax   = (ax < 0) ? -ax : ax;
							lobe = (FC_HZ * ax) / FS_HZ;
							pos  = !lobe[0] ^ flip;
							push_sample(pos ? SAMPLE_MAX : SAMPLE_MIN, pos ? SAMPLE_MIN : SAMPLE_MAX);
						end
					end
				endcase
			end
		end
		@(negedge clk);
		sample_valid <= 1'b0;

		// Drain outstanding outputs, then allow for stray ones
		wait (outstanding == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

[sim.f]
design/cdfir_pkg.sv
design/cdfir_ctrl.sv
design/cdfir_dp.sv
design/complex_decimating_fir.sv
verif/cdfir_output_check.sv
verif/tb_complex_decimating_fir.sv
